[rtl/nrp_pkg.sv]
// ----------------------------------------------------------------------------
// nrp_pkg
// shared types, character codes, field positions and limits of the parser
// ----------------------------------------------------------------------------
package nrp_pkg;

  // characters of the sentence
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_A      = 8'h41;

  // field positions within the sentence
  localparam logic [3:0] FLD_TIME    = 4'd1;
  localparam logic [3:0] FLD_STATUS  = 4'd2;
  localparam logic [3:0] FLD_LAT     = 4'd3;
  localparam logic [3:0] FLD_LAT_DIR = 4'd4;
  localparam logic [3:0] FLD_LON     = 4'd5;
  localparam logic [3:0] FLD_LON_DIR = 4'd6;
  localparam logic [3:0] POS_MAX     = 4'd15;
  localparam logic [3:0] FLD_MAX     = 4'd15;

  // number accumulation
  localparam logic [2:0]  FRACTION_DIGITS = 3'd4;
  localparam logic [16:0] INT_SAT         = 17'd131071;
  localparam logic [6:0]  SAT_REM         = 7'd71;
  localparam logic [30:0] SAT_DEG_MICRO   = 31'd1310000000;

  localparam logic [31:0] LAT_LIMIT = 32'd90000000;
  localparam logic [31:0] LON_LIMIT = 32'd180000000;

  localparam logic [3:0] SLOT_EMPTY = 4'd15;
  localparam int unsigned TIME_SLOTS = 10;

  // per-request control from the front end to the datapath units
  typedef struct packed {
    logic       fire;     // request is processed this cycle
    logic       clr_sent; // '$' or line end
    logic       clr_num;  // '$', line end or comma
    logic       num_en;   // other character inside a coordinate field
    logic       time_en;  // other character inside the time field
    logic [7:0] ch;
    logic [3:0] pos;
  } nrp_step_t;

  // unsigned coordinate magnitude before clamping, and its sign
  typedef struct packed {
    logic [31:0] mag;
    logic        neg;
  } nrp_coord_t;

  // 10^k = 60*m + s, for the weight of a fraction digit
  typedef struct packed {
    logic [10:0] m;
    logic [5:0]  s;
  } nrp_frac_t;

  function automatic nrp_frac_t frac_const(input logic [2:0] k);
    nrp_frac_t f;
    case (k)
      3'd5:    f = '{m: 11'd1666, s: 6'd40};
      3'd4:    f = '{m: 11'd166,  s: 6'd40};
      3'd3:    f = '{m: 11'd16,   s: 6'd40};
      3'd2:    f = '{m: 11'd1,    s: 6'd40};
      3'd1:    f = '{m: 11'd0,    s: 6'd10};
      3'd0:    f = '{m: 11'd0,    s: 6'd1};
      default: f = '{m: 11'd0,    s: 6'd0};
    endcase
    return f;
  endfunction

endpackage

[rtl/nrp_number.sv]
// ----------------------------------------------------------------------------
// nrp_number
// decimal coordinate accumulator, kept as degrees*1e6 plus minutes/60 quotient
// ----------------------------------------------------------------------------
module nrp_number #(
  parameter logic [2:0] FRACTION_DIGITS = nrp_pkg::FRACTION_DIGITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nrp_pkg::nrp_step_t  step,
  output nrp_pkg::nrp_coord_t coord
);

  logic [16:0] int_r, int_nxt;
  logic [6:0]  rem_r, rem_nxt;     // integer part mod 100
  logic [30:0] deg_r, deg_nxt;     // (integer part / 100) * 1e6
  logic [20:0] quo_r, quo_nxt;     // floor(minutes * 1e6 / 60) so far
  logic [5:0]  res_r, res_nxt;     // remainder of that division
  logic [2:0]  fc_r, fc_nxt;
  logic        frac_r, frac_nxt;
  logic        stop_r, stop_nxt;
  logic        neg_r, neg_nxt;

  logic              is_digit;
  logic [3:0]        dig;
  nrp_pkg::nrp_frac_t fk;
  logic [8:0]        ds;
  logic [2:0]        qd;
  logic [5:0]        rd;
  logic [14:0]       qa;
  logic [6:0]        rsum;
  logic              carry;
  logic [20:0]       n_int;
  logic              sat;
  logic [3:0]        tens, ones;
  logic [6:0]        rem_i, rem_use;
  logic [34:0]       deg_i;
  logic [7:0]        t2;
  logic [6:0]        f3;
  logic [1:0]        m3;

  assign is_digit = (step.ch >= nrp_pkg::CH_ZERO) && (step.ch <= nrp_pkg::CH_NINE);
  assign dig      = 4'(step.ch - nrp_pkg::CH_ZERO);

  // fraction digit weight 10^(5-c), split over 60
  assign fk    = nrp_pkg::frac_const(3'd5 - fc_r);
  assign ds    = 9'(dig) * 9'(fk.s);
  assign qd    = 3'((19'(ds) * 19'd1093) >> 16);
  assign rd    = 6'(ds - 9'(qd) * 9'd60);
  assign qa    = 15'(dig) * 15'(fk.m) + 15'(qd);
  assign rsum  = 7'(res_r) + 7'(rd);
  assign carry = (rsum >= 7'd60);

  // integer digit: track mod 100 and the degree part separately
  assign n_int   = 21'(int_r) * 21'd10 + 21'(dig);
  assign sat     = (n_int > 21'(nrp_pkg::INT_SAT));
  assign tens    = 4'((15'(rem_r) * 15'd205) >> 11);
  assign ones    = 4'(rem_r - 7'(tens) * 7'd10);
  assign rem_i   = 7'(ones) * 7'd10 + 7'(dig);
  assign deg_i   = 35'(deg_r) * 35'd10 + 35'(tens) * 35'd1000000;
  assign rem_use = sat ? nrp_pkg::SAT_REM : rem_i;
  // rem * 1e6 / 60 = rem * 16666 + floor(2 rem / 3)
  assign t2      = 8'(rem_use) * 8'd2;
  assign f3      = 7'((16'(t2) * 16'd171) >> 9);
  assign m3      = 2'(t2 - 8'(f3) * 8'd3);

  always_comb begin
    int_nxt  = int_r;
    rem_nxt  = rem_r;
    deg_nxt  = deg_r;
    quo_nxt  = quo_r;
    res_nxt  = res_r;
    fc_nxt   = fc_r;
    frac_nxt = frac_r;
    stop_nxt = stop_r;
    neg_nxt  = neg_r;
    if (step.fire && step.clr_num) begin
      int_nxt  = '0;
      rem_nxt  = '0;
      deg_nxt  = '0;
      quo_nxt  = '0;
      res_nxt  = '0;
      fc_nxt   = '0;
      frac_nxt = 1'b0;
      stop_nxt = 1'b0;
      neg_nxt  = 1'b0;
    end else if (step.fire && step.num_en && !stop_r) begin
      if (is_digit) begin
        if (frac_r) begin
          if (fc_r < FRACTION_DIGITS) begin
            fc_nxt  = fc_r + 3'd1;
            res_nxt = carry ? 6'(rsum - 7'd60) : 6'(rsum);
            quo_nxt = quo_r + 21'(qa) + 21'(carry);
          end
        end else begin
          int_nxt = sat ? nrp_pkg::INT_SAT : n_int[16:0];
          rem_nxt = rem_use;
          deg_nxt = sat ? nrp_pkg::SAT_DEG_MICRO : deg_i[30:0];
          quo_nxt = 21'(rem_use) * 21'd16666 + 21'(f3);
          res_nxt = 6'(m3) * 6'd20;
        end
      end else if (step.ch == nrp_pkg::CH_DOT) begin
        if (frac_r) begin
          stop_nxt = 1'b1;
        end else begin
          frac_nxt = 1'b1;
        end
      end else if (step.pos == '0 && step.ch == nrp_pkg::CH_MINUS) begin
        neg_nxt = 1'b1;
      end else if (step.pos == '0 && step.ch == nrp_pkg::CH_PLUS) begin
        neg_nxt = neg_r;
      end else begin
        stop_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r  <= '0;
      rem_r  <= '0;
      deg_r  <= '0;
      quo_r  <= '0;
      res_r  <= '0;
      fc_r   <= '0;
      frac_r <= 1'b0;
      stop_r <= 1'b0;
      neg_r  <= 1'b0;
    end else begin
      int_r  <= int_nxt;
      rem_r  <= rem_nxt;
      deg_r  <= deg_nxt;
      quo_r  <= quo_nxt;
      res_r  <= res_nxt;
      fc_r   <= fc_nxt;
      frac_r <= frac_nxt;
      stop_r <= stop_nxt;
      neg_r  <= neg_nxt;
    end
  end

  assign coord.mag = {1'b0, deg_r} + 32'(quo_r);
  assign coord.neg = neg_r;

endmodule

[rtl/nrp_time.sv]
// ----------------------------------------------------------------------------
// nrp_time
// time field digit slots and their decoded hour, minute, second and milli
// ----------------------------------------------------------------------------
module nrp_time (
  input  logic               clk,
  input  logic               rst_n,
  input  nrp_pkg::nrp_step_t step,
  output logic [6:0]         hour,
  output logic [6:0]         minute,
  output logic [6:0]         second,
  output logic [13:0]        milli
);

  logic [3:0] slot_r [nrp_pkg::TIME_SLOTS];
  logic [3:0] slot_idx;
  logic       slot_hit;
  logic [3:0] slot_val;
  logic [13:0] m2, m3;

  // positions 0-5 and 7-10 map to slots, the point at 6 is skipped
  always_comb begin
    slot_hit = 1'b0;
    slot_idx = '0;
    if (step.pos <= 4'd5) begin
      slot_hit = 1'b1;
      slot_idx = step.pos;
    end else if (step.pos >= 4'd7 && step.pos <= 4'd10) begin
      slot_hit = 1'b1;
      slot_idx = step.pos - 4'd1;
    end
  end

  assign slot_val = ((step.ch >= nrp_pkg::CH_ZERO) && (step.ch <= nrp_pkg::CH_NINE)) ?
                    4'(step.ch - nrp_pkg::CH_ZERO) : nrp_pkg::SLOT_EMPTY;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < nrp_pkg::TIME_SLOTS; i++) slot_r[i] <= '0;
    end else if (step.fire && step.clr_sent) begin
      for (int i = 0; i < nrp_pkg::TIME_SLOTS; i++) slot_r[i] <= nrp_pkg::SLOT_EMPTY;
    end else if (step.fire && step.time_en && slot_hit) begin
      slot_r[slot_idx] <= slot_val;
    end
  end

  // reading stops at the first empty slot
  function automatic logic [6:0] pair_val(input logic [3:0] a, input logic [3:0] b);
    logic [6:0] v;
    if (a > 4'd9) begin
      v = '0;
    end else if (b > 4'd9) begin
      v = 7'(a);
    end else begin
      v = 7'(a) * 7'd10 + 7'(b);
    end
    return v;
  endfunction

  assign hour   = pair_val(slot_r[0], slot_r[1]);
  assign minute = pair_val(slot_r[2], slot_r[3]);
  assign second = pair_val(slot_r[4], slot_r[5]);

  assign m2 = 14'(pair_val(slot_r[6], slot_r[7]));
  assign m3 = m2 * 14'd10 + 14'(slot_r[8]);

  always_comb begin
    if (slot_r[6] > 4'd9 || slot_r[7] > 4'd9 || slot_r[8] > 4'd9) begin
      milli = m2;
    end else if (slot_r[9] > 4'd9) begin
      milli = m3;
    end else begin
      milli = m3 * 14'd10 + 14'(slot_r[9]);
    end
  end

endmodule

[rtl/nmea_rmc_position_parser.sv]
// ----------------------------------------------------------------------------
// nmea_rmc_position_parser
// a line end passes the input register, then the result register, before its
// result shows on out_; a stalled, full result register holds it in between
// throughput: one character per cycle; a stalled output holds back only a
// line end, every other character keeps flowing through the parse stage
// reset (synchronous, rst_n low) clears all parse state; time digits read 0
// ----------------------------------------------------------------------------
module nmea_rmc_position_parser #(
  parameter logic [2:0] FRACTION_DIGITS = nrp_pkg::FRACTION_DIGITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [27:0] out_latitude_micro,
  output logic signed [28:0] out_longitude_micro,
  output logic [6:0]         out_utc_hour,
  output logic [6:0]         out_utc_minute,
  output logic [6:0]         out_utc_second,
  output logic [13:0]        out_utc_milli,
  output logic               out_fix_active
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // sentence position
  logic [3:0] field_r, field_nxt;
  logic [3:0] pos_r, pos_nxt;

  // coordinate holds and status
  logic signed [27:0] lat_hold_r, lat_hold_nxt;
  logic signed [28:0] lon_hold_r, lon_hold_nxt;
  logic               fix_r, fix_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic signed [27:0] lat_out_r;
  logic signed [28:0] lon_out_r;
  logic [6:0]         hour_out_r, minute_out_r, second_out_r;
  logic [13:0]        milli_out_r;
  logic               fix_out_r;

  logic is_dollar, is_nl, is_comma, is_other, fire, pos_zero;
  nrp_pkg::nrp_step_t  step;
  nrp_pkg::nrp_coord_t coord;

  logic [26:0]        lat_mag;
  logic [27:0]        lon_mag;
  logic signed [27:0] lat_coord, lat_emit;
  logic signed [28:0] lon_coord, lon_emit;
  logic [6:0]         t_hour, t_minute, t_second;
  logic [13:0]        t_milli;

  // character classes of the request sitting in the input register
  assign is_dollar = (s1_byte_r == nrp_pkg::CH_DOLLAR);
  assign is_nl     = (s1_byte_r == nrp_pkg::CH_NL);
  assign is_comma  = (s1_byte_r == nrp_pkg::CH_COMMA);
  assign is_other  = !(is_dollar || is_nl || is_comma);
  assign pos_zero  = (pos_r == '0);

  // only a line end needs the result register, and only while it is full and stalled
  assign fire     = s1_valid_r && !(is_nl && out_valid_r && out_stall);
  assign in_stall = s1_valid_r && !fire;

  assign step.fire     = fire;
  assign step.clr_sent = is_dollar || is_nl;
  assign step.clr_num  = is_dollar || is_nl || is_comma;
  assign step.num_en   = is_other && (field_r == nrp_pkg::FLD_LAT || field_r == nrp_pkg::FLD_LON);
  assign step.time_en  = is_other && (field_r == nrp_pkg::FLD_TIME);
  assign step.ch       = s1_byte_r;
  assign step.pos      = pos_r;

  nrp_number #(
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_number (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .coord (coord)
  );

  nrp_time u_time (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .hour   (t_hour),
    .minute (t_minute),
    .second (t_second),
    .milli  (t_milli)
  );

  // clamp the accumulated magnitude and apply the number's own sign
  assign lat_mag   = (coord.mag > nrp_pkg::LAT_LIMIT) ? 27'(nrp_pkg::LAT_LIMIT) : coord.mag[26:0];
  assign lon_mag   = (coord.mag > nrp_pkg::LON_LIMIT) ? 28'(nrp_pkg::LON_LIMIT) : coord.mag[27:0];
  assign lat_coord = coord.neg ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
  assign lon_coord = coord.neg ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});

  // a line end right at the start of a direction field drops that coordinate
  assign lat_emit = (field_r == nrp_pkg::FLD_LAT_DIR && pos_zero) ? '0 : lat_hold_r;
  assign lon_emit = (field_r == nrp_pkg::FLD_LON_DIR && pos_zero) ? '0 : lon_hold_r;

  always_comb begin
    field_nxt    = field_r;
    pos_nxt      = pos_r;
    lat_hold_nxt = lat_hold_r;
    lon_hold_nxt = lon_hold_r;
    fix_nxt      = fix_r;
    if (fire) begin
      if (is_dollar || is_nl) begin
        // new sentence
        field_nxt    = '0;
        pos_nxt      = '0;
        lat_hold_nxt = '0;
        lon_hold_nxt = '0;
        fix_nxt      = 1'b0;
      end else if (is_comma) begin
        // close the current field
        field_nxt = (field_r == nrp_pkg::FLD_MAX) ? field_r : field_r + 4'd1;
        pos_nxt   = '0;
        case (field_r)
          nrp_pkg::FLD_LAT:     lat_hold_nxt = lat_coord;
          nrp_pkg::FLD_LAT_DIR: if (pos_zero) lat_hold_nxt = '0;
          nrp_pkg::FLD_LON:     lon_hold_nxt = lon_coord;
          nrp_pkg::FLD_LON_DIR: if (pos_zero) lon_hold_nxt = '0;
          default:              field_nxt = field_nxt;
        endcase
      end else begin
        pos_nxt = (pos_r == nrp_pkg::POS_MAX) ? pos_r : pos_r + 4'd1;
        if (pos_zero) begin
          // first character of status or direction fields
          case (field_r)
            nrp_pkg::FLD_STATUS: fix_nxt = (s1_byte_r == nrp_pkg::CH_A);
            nrp_pkg::FLD_LAT_DIR: begin
              if (s1_byte_r == nrp_pkg::CH_S) begin
                lat_hold_nxt = -lat_hold_r;
              end else if (s1_byte_r != nrp_pkg::CH_N) begin
                lat_hold_nxt = '0;
              end
            end
            nrp_pkg::FLD_LON_DIR: begin
              if (s1_byte_r == nrp_pkg::CH_W) begin
                lon_hold_nxt = -lon_hold_r;
              end else if (s1_byte_r != nrp_pkg::CH_E) begin
                lon_hold_nxt = '0;
              end
            end
            default: fix_nxt = fix_r;
          endcase
        end
      end
    end
  end

  // input register takes a request whenever the parse stage is free
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire && is_nl) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      field_r     <= '0;
      pos_r       <= '0;
      lat_hold_r  <= '0;
      lon_hold_r  <= '0;
      fix_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      field_r     <= field_nxt;
      pos_r       <= pos_nxt;
      lat_hold_r  <= lat_hold_nxt;
      lon_hold_r  <= lon_hold_nxt;
      fix_r       <= fix_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
    if (fire && is_nl) begin
      lat_out_r    <= lat_emit;
      lon_out_r    <= lon_emit;
      hour_out_r   <= t_hour;
      minute_out_r <= t_minute;
      second_out_r <= t_second;
      milli_out_r  <= t_milli;
      fix_out_r    <= fix_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_latitude_micro  = lat_out_r;
  assign out_longitude_micro = lon_out_r;
  assign out_utc_hour        = hour_out_r;
  assign out_utc_minute      = minute_out_r;
  assign out_utc_second      = second_out_r;
  assign out_utc_milli       = milli_out_r;
  assign out_fix_active      = fix_out_r;

  // a processed line end always presents a result on the next cycle
  a_nl_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_nl) |=> out_valid_r)
    else $error("line end did not produce a result");

  // sentence restart returns to the first field
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (is_dollar || is_nl)) |=> (field_r == '0 && pos_r == '0 && !fix_r))
    else $error("sentence restart left position state");

  // held coordinates never leave their clamp range
  a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lat_hold_r <= $signed(28'(nrp_pkg::LAT_LIMIT)) &&
     lat_hold_r >= -$signed(28'(nrp_pkg::LAT_LIMIT))))
    else $error("latitude hold out of range");

  a_lon_range: assert property (@(posedge clk) disable iff (!rst_n)
    (lon_hold_r <= $signed(29'(nrp_pkg::LON_LIMIT)) &&
     lon_hold_r >= -$signed(29'(nrp_pkg::LON_LIMIT))))
    else $error("longitude hold out of range");

endmodule

[sim/nrp_checker.sv]
// ----------------------------------------------------------------------------
// nrp_checker
// watches both channels of the rmc parser, tracks the sentence being parsed
// and compares every emitted fix against its predicted value
// ----------------------------------------------------------------------------
module nrp_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [27:0] out_latitude_micro,
  input  logic signed [28:0] out_longitude_micro,
  input  logic [6:0]         out_utc_hour,
  input  logic [6:0]         out_utc_minute,
  input  logic [6:0]         out_utc_second,
  input  logic [13:0]        out_utc_milli,
  input  logic               out_fix_active,
  output int unsigned        fail_count,
  output int unsigned        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [27:0] lat;
    logic [28:0] lon;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [13:0] milli;
    logic        fix;
  } rmc_fix_t;

  rmc_fix_t    rmc_fix_q[$];

  // copy of the parse state
  logic [3:0]  fld;
  logic [3:0]  pos;
  logic [16:0] int_acc;
  logic [19:0] frac_acc;
  logic [2:0]  frac_cnt;
  logic        in_frac;
  logic        stopped;
  logic        negative;
  longint      lat_hold;
  longint      lon_hold;
  logic [3:0]  digits [nrp_pkg::TIME_SLOTS];
  logic [7:0]  status;

  task automatic note_failure(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task clear_number();
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = '0;
    in_frac  = 1'b0;
    stopped  = 1'b0;
    negative = 1'b0;
  endtask

  task clear_sentence(input logic [3:0] slot_fill);
    fld      = '0;
    pos      = '0;
    clear_number();
    lat_hold = 0;
    lon_hold = 0;
    status   = '0;
    for (int i = 0; i < nrp_pkg::TIME_SLOTS; i++) digits[i] = slot_fill;
  endtask

  // degrees in millionths from ddmm.f / dddmm.f
  function automatic longint coord_micro(input longint unsigned limit);
    longint unsigned scale, deg, mins, mag;
    scale = 1;
    repeat (frac_cnt) scale = scale * 10;
    deg  = int_acc / 100;
    mins = (int_acc % 100) * scale + frac_acc;
    mag  = deg * 1000000 + (mins * 1000000) / (60 * scale);
    if (mag > limit) mag = limit;
    return negative ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint orient(input longint v, input logic [7:0] ch,
                                    input logic [7:0] keep, input logic [7:0] flip);
    if (ch == keep) return v;
    if (ch == flip) return -v;
    return 0;
  endfunction

  // digits of slots lo..hi, stopping at the first empty slot
  function automatic longint unsigned time_value(input int lo, input int hi);
    longint unsigned v;
    v = 0;
    for (int i = lo; i <= hi; i++) begin
      if (digits[i] > 4'd9) break;
      v = v * 10 + digits[i];
    end
    return v;
  endfunction

  task close_field(input bit line_end);
    case (fld)
      nrp_pkg::FLD_LAT:     if (!line_end) lat_hold = coord_micro(nrp_pkg::LAT_LIMIT);
      nrp_pkg::FLD_LAT_DIR: if (pos == 0) lat_hold = 0;
      nrp_pkg::FLD_LON:     if (!line_end) lon_hold = coord_micro(nrp_pkg::LON_LIMIT);
      nrp_pkg::FLD_LON_DIR: if (pos == 0) lon_hold = 0;
      default: ;
    endcase
  endtask

  task number_char(input logic [7:0] ch);
    logic [31:0] grown;
    if (stopped) return;
    if (ch >= nrp_pkg::CH_ZERO && ch <= nrp_pkg::CH_NINE) begin
      if (in_frac) begin
        if (frac_cnt < nrp_pkg::FRACTION_DIGITS) begin
          frac_acc = 20'(frac_acc * 20'd10 + 20'(ch - nrp_pkg::CH_ZERO));
          frac_cnt++;
        end
      end else begin
        grown   = 32'(int_acc) * 10 + 32'(ch - nrp_pkg::CH_ZERO);
        int_acc = (grown > nrp_pkg::INT_SAT) ? nrp_pkg::INT_SAT : grown[16:0];
      end
    end else if (ch == nrp_pkg::CH_DOT) begin
      if (in_frac) stopped = 1'b1;
      else in_frac = 1'b1;
    end else if (pos == 0 && ch == nrp_pkg::CH_MINUS) begin
      negative = 1'b1;
    end else if (!(pos == 0 && ch == nrp_pkg::CH_PLUS)) begin
      stopped = 1'b1;
    end
  endtask

  task track_sentence(input logic [7:0] ch);
    rmc_fix_t f;
    int slot;
    if (ch == nrp_pkg::CH_DOLLAR) begin
      clear_sentence(nrp_pkg::SLOT_EMPTY);
    end else if (ch == nrp_pkg::CH_NL) begin
      close_field(1'b1);
      f.lat    = lat_hold[27:0];
      f.lon    = lon_hold[28:0];
      f.hour   = 7'(time_value(0, 1));
      f.minute = 7'(time_value(2, 3));
      f.second = 7'(time_value(4, 5));
      f.milli  = 14'(time_value(6, 9));
      f.fix    = (status == nrp_pkg::CH_A);
      rmc_fix_q.push_back(f);
      clear_sentence(nrp_pkg::SLOT_EMPTY);
    end else if (ch == nrp_pkg::CH_COMMA) begin
      close_field(1'b0);
      if (fld < nrp_pkg::FLD_MAX) fld++;
      pos = '0;
      clear_number();
    end else begin
      case (fld)
        nrp_pkg::FLD_TIME: begin
          // position 6 is the decimal point and has no slot
          slot = 10;
          if (pos <= 5) slot = int'(pos);
          else if (pos >= 7 && pos <= 10) slot = int'(pos) - 1;
          if (slot < 10)
            digits[slot] = (ch >= nrp_pkg::CH_ZERO && ch <= nrp_pkg::CH_NINE) ?
                           4'(ch - nrp_pkg::CH_ZERO) : nrp_pkg::SLOT_EMPTY;
        end
        nrp_pkg::FLD_STATUS:  if (pos == 0) status = ch;
        nrp_pkg::FLD_LAT, nrp_pkg::FLD_LON: number_char(ch);
        nrp_pkg::FLD_LAT_DIR:
          if (pos == 0) lat_hold = orient(lat_hold, ch, nrp_pkg::CH_N, nrp_pkg::CH_S);
        nrp_pkg::FLD_LON_DIR:
          if (pos == 0) lon_hold = orient(lon_hold, ch, nrp_pkg::CH_E, nrp_pkg::CH_W);
        default: ;
      endcase
      if (pos < nrp_pkg::POS_MAX) pos++;
    end
  endtask

  always @(posedge clk) begin
    rmc_fix_t want;
    if (!rst_n) begin
      clear_sentence(4'd0);
      rmc_fix_q.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rmc_fix_q.size() == 0) begin
          note_failure("fix emitted with nothing expected");
        end else begin
          want = rmc_fix_q.pop_front();
          if (out_latitude_micro !== want.lat)
            note_failure($sformatf("latitude got %0d expected %0d",
                                   out_latitude_micro, $signed(want.lat)));
          if (out_longitude_micro !== want.lon)
            note_failure($sformatf("longitude got %0d expected %0d",
                                   out_longitude_micro, $signed(want.lon)));
          if (out_utc_hour !== want.hour)
            note_failure($sformatf("hour got %0d expected %0d", out_utc_hour, want.hour));
          if (out_utc_minute !== want.minute)
            note_failure($sformatf("minute got %0d expected %0d",
                                   out_utc_minute, want.minute));
          if (out_utc_second !== want.second)
            note_failure($sformatf("second got %0d expected %0d",
                                   out_utc_second, want.second));
          if (out_utc_milli !== want.milli)
            note_failure($sformatf("milli got %0d expected %0d", out_utc_milli, want.milli));
          if (out_fix_active !== want.fix)
            note_failure($sformatf("fix flag got %0b expected %0b", out_fix_active, want.fix));
        end
      end
      if (in_valid && !in_stall) track_sentence(in_rx_byte);
      pending <= rmc_fix_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// drives rmc sentences, directed corner cases then random well-formed and
// broken sentences with noise, through the parser under random idling on
// both sides; the checker beside the block predicts and compares every fix
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // random part is split over three idling phases
  localparam int unsigned RANDOM_ITEMS = 1140;
  localparam int unsigned MIN_LINES    = 12;
  localparam longint      CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic signed [27:0] out_latitude_micro;
  logic signed [28:0] out_longitude_micro;
  logic [6:0]         out_utc_hour;
  logic [6:0]         out_utc_minute;
  logic [6:0]         out_utc_second;
  logic [13:0]        out_utc_milli;
  logic               out_fix_active;

  int unsigned fail_count;
  int unsigned pending;
  longint      cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned lines_sent     = 0;
  logic [7:0]  line_bytes[$];

  nmea_rmc_position_parser uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_latitude_micro  (out_latitude_micro),
    .out_longitude_micro (out_longitude_micro),
    .out_utc_hour        (out_utc_hour),
    .out_utc_minute      (out_utc_minute),
    .out_utc_second      (out_utc_second),
    .out_utc_milli       (out_utc_milli),
    .out_fix_active      (out_fix_active)
  );

  nrp_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_latitude_micro  (out_latitude_micro),
    .out_longitude_micro (out_longitude_micro),
    .out_utc_hour        (out_utc_hour),
    .out_utc_minute      (out_utc_minute),
    .out_utc_second      (out_utc_second),
    .out_utc_milli       (out_utc_milli),
    .out_fix_active      (out_fix_active),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog against a hung handshake or a lost fix
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request: optional idle gap, then hold the byte until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (b == nrp_pkg::CH_NL) lines_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold off the sender until every predicted fix has come out; the checker
  // publishes its count as a registered value, hence the wait before polling it
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  task automatic push_digits(input int unsigned n, input bit nines);
    repeat (n) line_bytes.push_back(nines ? nrp_pkg::CH_NINE :
                                    nrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // printable junk, commas and dollars included now and then
  function automatic logic [7:0] junk_char();
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  // coordinate field: sign, integer digits, fraction, sometimes a stray char
  task automatic push_coord(input int unsigned nominal);
    int unsigned r;
    bit          nines;
    nines = ($urandom_range(0, 19) == 0);
    r     = $urandom_range(0, 99);
    if (r < 4) line_bytes.push_back(nrp_pkg::CH_MINUS);
    else if (r < 7) line_bytes.push_back(nrp_pkg::CH_PLUS);
    push_digits(($urandom_range(0, 4) == 0) ? $urandom_range(0, 8) : nominal, nines);
    if ($urandom_range(0, 99) < 85) begin
      line_bytes.push_back(nrp_pkg::CH_DOT);
      push_digits($urandom_range(0, 6), nines);
    end
    if ($urandom_range(0, 9) == 0)
      line_bytes.push_back($urandom_range(0, 1) ? nrp_pkg::CH_DOT : junk_char());
  endtask

  // direction field: mostly one of the two letters, else empty or junk
  task automatic push_dir(input logic [7:0] keep, input logic [7:0] flip);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: line_bytes.push_back(keep);
      4, 5, 6, 7: line_bytes.push_back(flip);
      8:          ;
      default:    line_bytes.push_back(junk_char());
    endcase
    if ($urandom_range(0, 9) == 0) line_bytes.push_back(junk_char());
  endtask

  // one random sentence: mostly well formed, some cut short or with noise
  task automatic make_sentence();
    int unsigned r;
    line_bytes.delete();
    if ($urandom_range(0, 99) < 92) line_bytes.push_back(nrp_pkg::CH_DOLLAR);
    push_text("GPRMC");
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    r = $urandom_range(0, 9);
    if (r == 1) begin
      repeat ($urandom_range(0, 12)) line_bytes.push_back(junk_char());
    end else if (r != 0) begin
      push_digits(($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 6, 1'b0);
      if ($urandom_range(0, 99) < 80) begin
        line_bytes.push_back(nrp_pkg::CH_DOT);
        push_digits($urandom_range(0, 5), 1'b0);
      end
    end
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    case ($urandom_range(0, 7))
      0, 1, 2, 3: line_bytes.push_back(nrp_pkg::CH_A);
      4, 5:       line_bytes.push_back("V");
      6:          ;
      default:    line_bytes.push_back(junk_char());
    endcase
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    push_coord(4);
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    push_dir(nrp_pkg::CH_N, nrp_pkg::CH_S);
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    push_coord(5);
    line_bytes.push_back(nrp_pkg::CH_COMMA);
    push_dir(nrp_pkg::CH_E, nrp_pkg::CH_W);
    // trailing fields; a long run of them pushes the field count to its cap
    repeat (($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 5)) begin
      line_bytes.push_back(nrp_pkg::CH_COMMA);
      push_digits($urandom_range(0, 4), 1'b0);
    end
    if ($urandom_range(0, 1)) push_text("*6A");
    if ($urandom_range(0, 99) < 80) line_bytes.push_back(8'h0D);
    if ($urandom_range(0, 99) < 97) line_bytes.push_back(nrp_pkg::CH_NL);
    // broken sentence: line end somewhere in the middle
    if ($urandom_range(0, 99) < 8) begin
      r = $urandom_range(0, line_bytes.size() - 1);
      while (line_bytes.size() > r) void'(line_bytes.pop_back());
      line_bytes.push_back(nrp_pkg::CH_NL);
    end
    // a stray byte of any value
    if ($urandom_range(0, 99) < 10)
      line_bytes.insert($urandom_range(0, line_bytes.size() - 1), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    int unsigned start_bytes, start_lines;
    send_idle_pct  = snd_pct;
    recv_stall_pct = rcv_pct;
    start_bytes    = bytes_sent;
    start_lines    = lines_sent;
    while (bytes_sent - start_bytes < RANDOM_ITEMS / 3 ||
           lines_sent - start_lines < MIN_LINES / 3) begin
      make_sentence();
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 37;
    recv_stall_pct = 73;
    // line end straight after reset: time digits still read zero
    send_text("\n");
    // extreme byte values, then a sentence with no leading dollar
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("X,235959.999,A,4916.45,N,12311.12,W\r\n");
    send_text("$GPRMC,123519.5678,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
    // saturating integer parts, clamped and negated
    send_text("$GPRMC,999999.99999,A,999999999.999999,S,9999999999.9999999,W\n");
    // empty fields hold their places
    send_text("$GPRMC,,,,,,\n");
    send_text("$GPRMC,,V,4807.038,,01131.000,\n");
    // non-digits in time, signs, second point, junk and bad direction letters
    send_text("$GPRMC,12a456.7b9,A,-4807.03.8,Nx,+0113x1.5,e\n");
    // line end inside or before a coordinate
    send_text("$GPRMC,1234,A,4807\n");
    send_text("$GPRMC,123456,A,4807.1,N,0113\n");
    // restart in mid sentence, fraction-only values
    send_text("$GPRMC,1234$GPRMC,5678,,.5,S,-.25,W\n");
    // field count runs into its cap
    send_text("$,,,,,,,,,,,,,,,,,,,,1\n");
    send_text("$GPRMC,000000.0000,A,0000.0000,N,00000.0000,E,,\n");
    send_text("$GPRMC,235959,A,9000.0000,S,18000.0000,W\n");
    wait_drained();

    run_phase(37, 73);
    run_phase(73, 37);
    run_phase(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
